### rtl/mwld_pkg.sv
// ----------------------------------------------------------------------------
// mwld_pkg
// Shared types and constants for the magic-word, length-prefixed deframer.
// ----------------------------------------------------------------------------
package mwld_pkg;

    // Default and upper bound of the sync pattern size in bytes
    localparam int MAX_PATTERN_BYTES_DEF = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_PATTERN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH  = 1'b1;

    // Configuration data port width (widest register)
    localparam int CFG_DATA_W = 64;

    // Deframer phase
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DRAIN   = 2'd3
    } t_phase;

    // Result kind codes
    typedef enum logic [2:0] {
        K_PAYLOAD = 3'd0,
        K_EMPTY   = 3'd1,
        K_NOPAT   = 3'd2,
        K_NEG     = 3'd3,
        K_CUT     = 3'd4
    } t_kind;

    // One result item
    typedef struct packed {
        logic [7:0] payload_byte;
        t_kind      result_kind;
        logic       payload_last;
    } t_result;

endpackage

### rtl/magic_word_length_deframer.sv
// ----------------------------------------------------------------------------
// magic_word_length_deframer
// Hunts for a sync pattern, gathers a 4-byte little-endian signed length and
// passes that many payload bytes, reporting empty, missing, negative and cut
// messages. Bytes after a message are dropped until the end of the buffer.
// ----------------------------------------------------------------------------
// Output: a result is registered in the output register, or in the skid
//   register when the output register is full and stalled.
// Throughput: one item per cycle while the skid register is empty; a two-entry
//   output buffer (output plus skid register) lets input run until it fills.
// Reset: synchronous active-low; returns to pattern hunt, pattern = 0,
//   pattern length = 1, output buffer empty.
module magic_word_length_deframer
    import mwld_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_buffer,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_payload_byte,
    output logic [2:0]            o_result_kind,
    output logic                  o_payload_last
);

    localparam int CntW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IdxW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int PatW = 8 * MAX_PATTERN_BYTES;

    // configuration registers
    logic [MAX_PATTERN_BYTES-1:0][7:0] r_pattern;
    logic [CntW-1:0]                   r_eff_len;
    logic [3:0]                        cfg_len;

    // deframer state
    t_phase          r_phase, n_phase;
    logic [CntW-1:0] r_match, n_match;
    logic [31:0]     r_gather, n_gather;
    logic [1:0]      r_seen, n_seen;
    logic [30:0]     r_remain, n_remain;

    // output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic        in_acc, out_take;
    logic        res_valid;
    t_result     res;
    logic [7:0]  pat_byte;
    logic [31:0] gather_new;
    logic [30:0] remain_dec;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;

    // Write configuration; clamp pattern length into 1..MAX
    assign cfg_len = i_cfg_data[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_eff_len <= CntW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAGIC_PATTERN: r_pattern <= i_cfg_data[PatW-1:0];
                CFG_MAGIC_LENGTH: begin
                    if (cfg_len == 4'd0) begin
                        r_eff_len <= CntW'(1);
                    end else if (cfg_len > 4'(MAX_PATTERN_BYTES)) begin
                        r_eff_len <= CntW'(MAX_PATTERN_BYTES);
                    end else begin
                        r_eff_len <= CntW'(cfg_len);
                    end
                end
            endcase
        end
    end

    // Datapath helpers
    assign pat_byte   = r_pattern[r_match[IdxW-1:0]];
    assign gather_new = r_gather | (32'(i_data_byte) << {r_seen, 3'b000});
    assign remain_dec = r_remain - 31'd1;

    // Next state and result for one accepted item
    always_comb begin
        n_phase   = r_phase;
        n_match   = r_match;
        n_gather  = r_gather;
        n_seen    = r_seen;
        n_remain  = r_remain;
        res_valid = 1'b0;
        res       = '{payload_byte: 8'd0, result_kind: K_PAYLOAD, payload_last: 1'b0};

        if (in_acc) begin
            unique case (r_phase) inside
                PH_HUNT, PH_LENGTH: begin
                    if (r_phase == PH_HUNT && r_match < r_eff_len) begin
                        // compare against the next pattern byte; restart on mismatch
                        if (i_data_byte == pat_byte) begin
                            n_match = CntW'(r_match + 1'b1);
                        end else begin
                            n_match = '0;
                        end
                        if (i_end_of_buffer) begin
                            res_valid = 1'b1;
                            res.result_kind  = K_NOPAT;
                            res.payload_last = 1'b1;
                        end
                    end else begin
                        // gather one length byte
                        n_phase  = PH_LENGTH;
                        n_gather = gather_new;
                        if (r_seen != 2'd3) begin
                            n_seen = r_seen + 2'd1;
                            if (i_end_of_buffer) begin
                                res_valid = 1'b1;
                                res.result_kind  = K_NOPAT;
                                res.payload_last = 1'b1;
                            end
                        end else begin
                            n_seen = 2'd0;
                            if (gather_new[31]) begin
                                res_valid = 1'b1;
                                res.result_kind  = K_NEG;
                                res.payload_last = 1'b1;
                                n_phase = PH_DRAIN;
                            end else if (gather_new == 32'd0) begin
                                res_valid = 1'b1;
                                res.result_kind  = K_EMPTY;
                                res.payload_last = 1'b1;
                                n_phase = PH_DRAIN;
                            end else begin
                                n_remain = gather_new[30:0];
                                n_phase  = PH_PAYLOAD;
                                if (i_end_of_buffer) begin
                                    res_valid = 1'b1;
                                    res.result_kind  = K_CUT;
                                    res.payload_last = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    // pass the byte and count down
                    n_remain  = remain_dec;
                    res_valid = 1'b1;
                    res.payload_byte = i_data_byte;
                    if (remain_dec == 31'd0) begin
                        res.payload_last = 1'b1;
                        n_phase = PH_DRAIN;
                    end else if (i_end_of_buffer) begin
                        res.result_kind  = K_CUT;
                        res.payload_last = 1'b1;
                    end
                end
                PH_DRAIN: begin
                    // drop bytes until the end of the buffer
                end
            endcase

            // rearm at the end of every buffer
            if (i_end_of_buffer) begin
                n_phase  = PH_HUNT;
                n_match  = '0;
                n_gather = '0;
                n_seen   = '0;
                n_remain = '0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_match  <= '0;
            r_gather <= '0;
            r_seen   <= '0;
            r_remain <= '0;
        end else begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_gather <= n_gather;
            r_seen   <= n_seen;
            r_remain <= n_remain;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out.payload_byte;
    assign o_result_kind  = r_out.result_kind;
    assign o_payload_last = r_out.payload_last;

    // Skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // Status results always close a message
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != K_PAYLOAD) |-> o_payload_last)
        else $error("status result without last flag");

    // Status-only kinds carry a zero byte
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == K_EMPTY || o_result_kind == K_NOPAT ||
                         o_result_kind == K_NEG)) |-> (o_payload_byte == 8'd0))
        else $error("status-only result with nonzero byte");

    // End of buffer rearms the deframer
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_buffer) |=>
            (r_phase == PH_HUNT && r_match == '0 && r_seen == 2'd0 && r_gather == 32'd0))
        else $error("deframer not rearmed after end of buffer");

    // Payload phase always has bytes left to pass
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remain != 31'd0))
        else $error("payload phase with zero remaining count");

endmodule
